@@ rtl/core/sobel_gradient_magnitude_direction_unit_assert.svh @@
// Assertion macros for the Sobel gradient unit.
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SGMD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SGMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SGMD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define SGMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/sgmd_pkg.sv @@
package sgmd_pkg;

	localparam int MAX_WIDTH = 2048;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 1;
	localparam int DIR_W   = 2;
	localparam int ABS_W   = 10;
	localparam int SQ_W    = 2 * ABS_W;
	localparam int SQRT_IN_W = 16;
	localparam int ROOT_W  = SQRT_IN_W / 2;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;
	localparam logic [CFG_W-1:0] BORDER       = 12'd2;

	// Sector bounds, scaled by 1024: tan(22.5) and tan(67.5).
	localparam logic [11:0] DIR_LO_K = 12'd424;
	localparam logic [11:0] DIR_HI_K = 12'd2472;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef enum logic [DIR_W-1:0] {
		DIR_HORIZONTAL = 2'd0,
		DIR_PLUS45     = 2'd1,
		DIR_VERTICAL   = 2'd2,
		DIR_MINUS45    = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_GRAD,
		S_SQR,
		S_SUM,
		S_ROOT,
		S_OUT
	} state_t;

endpackage

@@ rtl/core/sgmd_ram.sv @@
module sgmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/sgmd_isqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
module sgmd_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sgmd_pkg::SQRT_IN_W-1:0] radicand,
	output logic                           done,
	output logic [sgmd_pkg::ROOT_W-1:0]    root
);

	localparam int RW   = sgmd_pkg::ROOT_W;
	localparam int IW   = sgmd_pkg::SQRT_IN_W;
	localparam int STW  = $clog2(RW);
	localparam int REMW = RW + 1;

	logic            busy_q;
	logic            done_q;
	logic [STW-1:0]  step_q;
	logic [IW-1:0]   rad_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;

	logic [REMW+1:0] rem_sh;
	logic [REMW+1:0] trial;
	logic            take;
	logic [REMW+1:0] rem_sub;

	always_comb begin
		rem_sh  = {rem_q, rad_q[IW-1 -: 2]};
		trial   = (REMW + 2)'({root_q, 2'b01});
		take    = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[IW-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sub[REMW-1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REMW-1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/sobel_gradient_magnitude_direction_unit.sv @@
// Channel  | Direction | Signals
// s_axis   | in        | tvalid tready tdata[7:0]=pixel, tuser=start_of_frame
// m_axis   | out       | tvalid tready tdata[9:0]=magnitude,direction, tlast=end_of_row,
//          |           | tuser=end_of_frame
// cfg      | in        | valid ready index data (0 image_width, 1 image_height)
//
// A pixel that yields no result passes through a line store read and then the window update and
// write back. An interior pixel goes on through the gradient, square, sum, square root wait and
// output states; the square root wait covers eight steps of two radicand bits each and then
// its done flag. A wait on m_axis while the output register is full holds the output state.
// Reset clears the counters, the window and the registers to 640 by 480; the line store
// needs no clearing. A stalled result sits in the output register while the next pixel
// is taken.
`include "sobel_gradient_magnitude_direction_unit_assert.svh"

module sobel_gradient_magnitude_direction_unit #(
	parameter int MAX_WIDTH = sgmd_pkg::MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [sgmd_pkg::PIX_W-1:0]            s_axis_tdata,   // pixel
	input  logic                                  s_axis_tuser,   // start_of_frame
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [sgmd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // magnitude, direction
	output logic                                  m_axis_tlast,   // end_of_row
	output logic                                  m_axis_tuser,   // end_of_frame
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sgmd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sgmd_pkg::CFG_W-1:0]            cfg_data
);

	localparam int PW   = sgmd_pkg::PIX_W;
	localparam int CW   = sgmd_pkg::CFG_W;
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (AW + 1 > CW) ? AW + 1 : CW;
	localparam int XW   = sgmd_pkg::ABS_W;
	localparam int SW   = sgmd_pkg::SQ_W;
	localparam int DW   = 22;

	sgmd_pkg::state_t state_q, state_d;

	logic [CW-1:0] image_width_q;
	logic [CW-1:0] image_height_q;

	logic [AW-1:0] col_q;
	logic [CW-1:0] row_q;

	logic [PW-1:0] win_q [9];

	logic          in_accept;
	logic          ram_wr_en;
	logic          sqrt_start;
	logic          out_load;

	// Position bookkeeping for the pixel at the input.
	logic [CMPW-1:0] w_eff;
	logic [CW-1:0]   h_eff;
	logic [AW-1:0]   c_eff;
	logic [CW-1:0]   r_eff;
	logic            last_col;
	logic            last_row;
	logic [AW-1:0]   col_d;
	logic [CW-1:0]   row_d;
	logic            emit_d;

	always_comb begin
		if (CMPW'(image_width_q) < CMPW'(sgmd_pkg::MIN_DIM)) begin
			w_eff = CMPW'(sgmd_pkg::MIN_DIM);
		end else if (CMPW'(image_width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(image_width_q);
		end
		h_eff = (image_height_q < sgmd_pkg::MIN_DIM) ? sgmd_pkg::MIN_DIM : image_height_q;

		c_eff = (s_axis_tuser || CMPW'(col_q) >= w_eff) ? '0 : col_q;
		r_eff = (s_axis_tuser || row_q >= h_eff) ? '0 : row_q;

		last_col = (CMPW'(c_eff) + CMPW'(1)) >= w_eff;
		last_row = ({1'b0, r_eff} + (CW + 1)'(1)) >= {1'b0, h_eff};

		if (last_col) begin
			col_d = '0;
			row_d = last_row ? '0 : r_eff + 1'b1;
		end else begin
			col_d = c_eff + 1'b1;
			row_d = r_eff;
		end
		emit_d = (r_eff >= sgmd_pkg::BORDER) && (CW'(c_eff) >= sgmd_pkg::BORDER);
	end

	// Configuration writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= sgmd_pkg::WIDTH_RESET;
			image_height_q <= sgmd_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sgmd_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				sgmd_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Per-item registers captured at the input beat.
	logic          emit_q;
	logic [PW-1:0] px_q;
	logic [AW-1:0] pix_col_q;
	logic          eor_q;
	logic          eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			emit_q <= 1'b0;
		end else if (in_accept) begin
			col_q  <= col_d;
			row_q  <= row_d;
			emit_q <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q      <= s_axis_tdata;
			pix_col_q <= c_eff;
			eor_q     <= last_col;
			eof_q     <= last_col && last_row;
		end
	end

	// Both line stores share one entry: upper byte is two rows back, lower byte one row back.
	logic [2*PW-1:0] ram_rd_data;
	logic [2*PW-1:0] ram_wr_data;

	assign ram_wr_data = {ram_rd_data[PW-1:0], px_q};

	sgmd_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (pix_col_q),
		.wr_data (ram_wr_data),
		.rd_en   (in_accept),
		.rd_addr (c_eff),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (ram_wr_en) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[2] <= ram_rd_data[2*PW-1:PW];
			win_q[5] <= ram_rd_data[PW-1:0];
			win_q[8] <= px_q;
		end
	end

	// Gradients from the window.
	logic [XW-1:0]   right_v, left_v, top_v, bottom_v;
	logic signed [XW:0] gx_v, gy_v;
	logic [XW:0]     ax_full, ay_full;

	always_comb begin
		right_v  = XW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + XW'(win_q[8]);
		left_v   = XW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + XW'(win_q[6]);
		top_v    = XW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + XW'(win_q[2]);
		bottom_v = XW'(win_q[6]) + {1'b0, win_q[7], 1'b0} + XW'(win_q[8]);
		gx_v     = signed'({1'b0, right_v}) - signed'({1'b0, left_v});
		gy_v     = signed'({1'b0, top_v}) - signed'({1'b0, bottom_v});
		ax_full  = gx_v[XW] ? unsigned'(-gx_v) : unsigned'(gx_v);
		ay_full  = gy_v[XW] ? unsigned'(-gy_v) : unsigned'(gy_v);
	end

	logic [XW-1:0] ax_q, ay_q;
	logic          gx_zero_q;
	logic          same_sign_q;

	always_ff @(posedge clk) begin
		if (state_q == sgmd_pkg::S_GRAD) begin
			ax_q        <= ax_full[XW-1:0];
			ay_q        <= ay_full[XW-1:0];
			gx_zero_q   <= (gx_v == '0);
			same_sign_q <= ((gx_v > 0) == (gy_v > 0));
		end
	end

	// Squares and the direction sector.
	logic [DW-1:0] a_v, lo_v, hi_v;
	sgmd_pkg::dir_t dir_v;

	always_comb begin
		a_v  = DW'({ay_q, 10'b0});
		lo_v = DW'(ax_q) * DW'(sgmd_pkg::DIR_LO_K);
		hi_v = DW'(ax_q) * DW'(sgmd_pkg::DIR_HI_K);
		if (gx_zero_q) begin
			dir_v = sgmd_pkg::DIR_VERTICAL;
		end else if (a_v <= lo_v) begin
			dir_v = sgmd_pkg::DIR_HORIZONTAL;
		end else if (a_v <= hi_v) begin
			dir_v = same_sign_q ? sgmd_pkg::DIR_PLUS45 : sgmd_pkg::DIR_MINUS45;
		end else begin
			dir_v = sgmd_pkg::DIR_VERTICAL;
		end
	end

	logic [SW-1:0]  sqx_q, sqy_q;
	sgmd_pkg::dir_t dir_q;

	always_ff @(posedge clk) begin
		if (state_q == sgmd_pkg::S_SQR) begin
			sqx_q <= SW'(ax_q) * SW'(ax_q);
			sqy_q <= SW'(ay_q) * SW'(ay_q);
			dir_q <= dir_v;
		end
	end

	logic [SW:0] sum_v;
	logic        sat_q;

	assign sum_v = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_ff @(posedge clk) begin
		if (sqrt_start) begin
			sat_q <= |sum_v[SW:sgmd_pkg::SQRT_IN_W];
		end
	end

	logic                        sqrt_done;
	logic [sgmd_pkg::ROOT_W-1:0] sqrt_root;

	sgmd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_v[sgmd_pkg::SQRT_IN_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgmd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgmd_pkg::S_IDLE: if (in_accept) state_d = sgmd_pkg::S_LOAD;
			sgmd_pkg::S_LOAD: state_d = emit_q ? sgmd_pkg::S_GRAD : sgmd_pkg::S_IDLE;
			sgmd_pkg::S_GRAD: state_d = sgmd_pkg::S_SQR;
			sgmd_pkg::S_SQR:  state_d = sgmd_pkg::S_SUM;
			sgmd_pkg::S_SUM:  state_d = sgmd_pkg::S_ROOT;
			sgmd_pkg::S_ROOT: if (sqrt_done) state_d = sgmd_pkg::S_OUT;
			sgmd_pkg::S_OUT:  if (!out_valid_q || m_axis_tready) state_d = sgmd_pkg::S_IDLE;
			default:          state_d = sgmd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_wr_en     = 1'b0;
		sqrt_start    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			sgmd_pkg::S_IDLE: s_axis_tready = 1'b1;
			sgmd_pkg::S_LOAD: ram_wr_en     = 1'b1;
			sgmd_pkg::S_SUM:  sqrt_start    = 1'b1;
			sgmd_pkg::S_OUT:  out_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	// Output register.
	logic [sgmd_pkg::PIX_W-1:0] out_mag_q;
	sgmd_pkg::dir_t             out_dir_q;
	logic                       out_eor_q;
	logic                       out_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mag_q <= sat_q ? '1 : sqrt_root;
			out_dir_q <= dir_q;
			out_eor_q <= eor_q;
			out_eof_q <= eof_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = sgmd_pkg::OUT_TDATA_W'({out_dir_q, out_mag_q});
	assign m_axis_tlast  = out_eor_q;
	assign m_axis_tuser  = out_eof_q;

	// Checks.
	`SGMD_ASSERT_IMPLIES(a_wr_follows_rd, clk, arst_n, ram_wr_en, $past(in_accept) && (pix_col_q == $past(c_eff)), "line store write without matching read")
	`SGMD_ASSERT_IMPLIES(a_root_in_wait, clk, arst_n, sqrt_done, state_q == sgmd_pkg::S_ROOT, "square root finished outside its wait state")
	`SGMD_ASSERT_NEXT(a_out_hold, clk, arst_n, (state_q == sgmd_pkg::S_OUT) && out_valid_q && !m_axis_tready, state_q == sgmd_pkg::S_OUT, "result left while output register was full")

endmodule
